>>> rtl/core/pse_pkg.sv
// Shared constants and types for the postfix stack evaluator.
`default_nettype none

package pse_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int DATA_WIDTH  = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int SP_W        = $clog2(STACK_DEPTH + 1);
    localparam int KIND_W      = 4;
    localparam int COMMA_W     = 6;

    typedef enum logic [KIND_W-1:0] {
        TK_PUSH = 4'd0,
        TK_ADD  = 4'd1,
        TK_SUB  = 4'd2,
        TK_MUL  = 4'd3,
        TK_DIV  = 4'd4,
        TK_NEG  = 4'd5,
        TK_IF   = 4'd6,
        TK_MIN  = 4'd7,
        TK_MAX  = 4'd8
    } token_t;

    typedef enum logic [1:0] {
        ERR_NONE  = 2'd0,
        ERR_DIV0  = 2'd1,
        ERR_UNDER = 2'd2,
        ERR_OVER  = 2'd3
    } err_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_POP,
        ST_CALC,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_FINISH,
        ST_REPORT
    } state_t;

endpackage

`default_nettype wire

>>> rtl/core/pse_divider.sv
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
`default_nettype none

module pse_divider
    import pse_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    input  wire logic [DATA_WIDTH-1:0] dividend,
    input  wire logic [DATA_WIDTH-1:0] divisor,
    output logic                       done,
    output logic [DATA_WIDTH-1:0]      quotient
);

    localparam int CNT_W = $clog2(DATA_WIDTH);

    logic                  busy_reg;
    logic                  done_reg;
    logic [CNT_W-1:0]      cnt_reg;
    logic [DATA_WIDTH-1:0] rem_reg;
    logic [DATA_WIDTH-1:0] quo_reg;
    logic [DATA_WIDTH-1:0] dsr_reg;
    logic                  neg_reg;

    logic [DATA_WIDTH:0]   shifted;
    logic [DATA_WIDTH:0]   diff;
    logic                  fits;

    assign shifted = {rem_reg, quo_reg[DATA_WIDTH-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = ~diff[DATA_WIDTH];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(DATA_WIDTH - 1);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend[DATA_WIDTH-1] ? ('0 - dividend) : dividend;
            dsr_reg <= divisor[DATA_WIDTH-1] ? ('0 - divisor) : divisor;
            neg_reg <= dividend[DATA_WIDTH-1] ^ divisor[DATA_WIDTH-1];
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[DATA_WIDTH-1:0] : shifted[DATA_WIDTH-1:0];
            quo_reg <= {quo_reg[DATA_WIDTH-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? ('0 - quo_reg) : quo_reg;

endmodule

`default_nettype wire

>>> rtl/core/postfix_stack_evaluator_core.sv
// Top level: postfix token sequencer, operand stack memory and shared ALU.
// One token is taken per word; in_stall stays high until it is finished.
// A push needs no further steps; an operator pops its N operands, one stack
// memory read per cycle, then writes its result back; divide waits on the
// bit-serial divider instead. A token marked last then reads the top of
// stack and loads the output register, which may then wait on out_stall.
// After any error later tokens are skipped until the last one, which reports
// result 0 with the first error code and clears the stack.
`default_nettype none

module postfix_stack_evaluator_core
    import pse_pkg::*;
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic [KIND_W-1:0]            req_type,
    input  wire logic signed [DATA_WIDTH-1:0] value,
    input  wire logic [COMMA_W-1:0]           comma_count,
    input  wire logic                         last_token,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic signed [DATA_WIDTH-1:0]      result,
    output logic [1:0]                        error_code
);

    state_t                state_reg, state_next;
    logic [SP_W-1:0]       sp_reg, sp_next;
    err_t                  err_reg, err_next;

    logic [KIND_W-1:0]     kind_reg;
    logic                  last_reg;
    logic [SP_W-1:0]       need_reg;
    logic [SP_W-1:0]       pop_cnt_reg;
    logic [ADDR_W-1:0]     rd_ptr_reg;
    logic [DATA_WIDTH-1:0] acc_reg;
    logic [DATA_WIDTH-1:0] opa_reg;

    logic                  out_valid_reg;
    logic [DATA_WIDTH-1:0] result_reg;
    err_t                  code_reg;

    logic [DATA_WIDTH-1:0] mem [STACK_DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    logic                  accept;
    logic                  out_free;
    logic [SP_W-1:0]       need;
    logic                  is_op;
    logic                  under;
    logic                  full;
    logic                  pop_last;
    logic [SP_W-1:0]       sp_m1;
    logic [SP_W-1:0]       sp_m2;
    logic [ADDR_W-1:0]     rd_addr;
    logic                  wr_en;
    logic [DATA_WIDTH-1:0] wr_data;
    logic [DATA_WIDTH-1:0] alu_out;
    logic [DATA_WIDTH-1:0] cmp_x;
    logic [DATA_WIDTH-1:0] cmp_y;
    logic                  take;
    logic                  div_start;
    logic                  div_done;
    logic [DATA_WIDTH-1:0] div_q;
    err_t                  final_err;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;
    assign sp_m1    = sp_reg - 1'b1;
    assign sp_m2    = sp_reg - SP_W'(2);
    assign full     = (sp_reg == SP_W'(STACK_DEPTH));
    assign pop_last = (pop_cnt_reg == need_reg - 1'b1);
    assign under    = (sp_reg < need);

    always_comb
    begin
        is_op = 1'b1;
        unique case (req_type)
            TK_NEG:          need = SP_W'(1);
            TK_IF:           need = SP_W'(3);
            TK_MIN, TK_MAX:  need = SP_W'(comma_count) + SP_W'(1);
            TK_ADD, TK_SUB,
            TK_MUL, TK_DIV:  need = SP_W'(2);
            default:
            begin
                need  = '0;
                is_op = 1'b0;
            end
        endcase
    end

    // shared compare: min/max fold, and the if condition on the third operand
    always_comb
    begin
        case (kind_reg)
            TK_MIN:
            begin
                cmp_x = acc_reg;
                cmp_y = rd_data_reg;
            end
            TK_MAX:
            begin
                cmp_x = rd_data_reg;
                cmp_y = acc_reg;
            end
            default:
            begin
                cmp_x = rd_data_reg;
                cmp_y = '0;
            end
        endcase
    end
    assign take = $signed(cmp_x) > $signed(cmp_y);

    always_comb
    begin
        case (kind_reg)
            TK_ADD:  alu_out = opa_reg + acc_reg;
            TK_SUB:  alu_out = opa_reg - acc_reg;
            TK_MUL:  alu_out = opa_reg * acc_reg;
            TK_NEG:  alu_out = '0 - acc_reg;
            default: alu_out = acc_reg;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (err_reg == ERR_NONE && is_op && !under)
                        state_next = ST_POP;
                    else
                        state_next = last_token ? ST_FINISH : ST_IDLE;
                end
            end
            ST_POP:
            begin
                if (pop_last)
                    state_next = (kind_reg == TK_DIV) ? ST_DIV_START : ST_CALC;
            end
            ST_CALC:
                state_next = last_reg ? ST_FINISH : ST_IDLE;
            ST_DIV_START:
            begin
                if (acc_reg == '0)
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
                else
                    state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = last_reg ? ST_FINISH : ST_IDLE;
            end
            ST_FINISH:
                state_next = ST_REPORT;
            ST_REPORT:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        in_stall  = 1'b1;
        wr_en     = 1'b0;
        wr_data   = alu_out;
        div_start = 1'b0;
        rd_addr   = sp_m1[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                in_stall = 1'b0;
                wr_data  = value;
                wr_en    = accept && err_reg == ERR_NONE && req_type == TK_PUSH && !full;
            end
            ST_POP:
                rd_addr = rd_ptr_reg;
            ST_CALC:
                wr_en = 1'b1;
            ST_DIV_START:
                div_start = (acc_reg != '0);
            ST_DIV_WAIT:
            begin
                wr_en   = div_done;
                wr_data = div_q;
            end
            ST_FINISH, ST_REPORT:
                rd_addr = sp_m1[ADDR_W-1:0];
            default:
                in_stall = 1'b1;
        endcase
    end

    assign final_err = (err_reg == ERR_NONE && sp_reg == '0) ? ERR_UNDER : err_reg;

    // stack pointer and sticky error
    always_comb
    begin
        sp_next  = sp_reg;
        err_next = err_reg;
        if (accept && err_reg == ERR_NONE)
        begin
            if (req_type == TK_PUSH)
            begin
                if (full)
                    err_next = ERR_OVER;
                else
                    sp_next = sp_reg + 1'b1;
            end
            else if (is_op)
            begin
                if (under)
                    err_next = ERR_UNDER;
                else
                    sp_next = sp_reg - need;
            end
        end
        if (state_reg == ST_CALC || (state_reg == ST_DIV_WAIT && div_done))
            sp_next = sp_reg + 1'b1;
        if (state_reg == ST_DIV_START && acc_reg == '0)
            err_next = ERR_DIV0;
        if (state_reg == ST_REPORT && out_free)
        begin
            sp_next  = '0;
            err_next = ERR_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            sp_reg        <= '0;
            err_reg       <= ERR_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sp_reg    <= sp_next;
            err_reg   <= err_next;
            if (state_reg == ST_REPORT && out_free)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= req_type;
            last_reg    <= last_token;
            need_reg    <= need;
            pop_cnt_reg <= '0;
            rd_ptr_reg  <= sp_m2[ADDR_W-1:0];
        end
        if (state_reg == ST_POP)
        begin
            pop_cnt_reg <= pop_cnt_reg + 1'b1;
            rd_ptr_reg  <= rd_ptr_reg - 1'b1;
            if (pop_cnt_reg == '0)
                acc_reg <= rd_data_reg;
            else if (kind_reg == TK_MIN || kind_reg == TK_MAX)
            begin
                if (take)
                    acc_reg <= rd_data_reg;
            end
            else if (pop_cnt_reg == SP_W'(1))
                opa_reg <= rd_data_reg;
            else if (take)
                acc_reg <= opa_reg;
        end
        if (state_reg == ST_REPORT && out_free)
        begin
            code_reg   <= final_err;
            result_reg <= (final_err == ERR_NONE) ? rd_data_reg : '0;
        end
    end

    // operand stack
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[sp_reg[ADDR_W-1:0]] <= wr_data;
        rd_data_reg <= mem[rd_addr];
    end

    pse_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (opa_reg),
        .divisor  (acc_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    assign out_valid  = out_valid_reg;
    assign result     = result_reg;
    assign error_code = code_reg;

    a_sp_range: assert property (@(posedge clk) disable iff (!rst_n)
        sp_reg <= SP_W'(STACK_DEPTH))
        else $error("stack pointer beyond depth");

    a_wr_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> sp_reg < SP_W'(STACK_DEPTH))
        else $error("stack write past the top");

    a_report_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REPORT && out_free) |=>
        (out_valid_reg && sp_reg == '0 && err_reg == ERR_NONE && state_reg == ST_IDLE))
        else $error("report did not clear the stack");

    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> (acc_reg != '0 && kind_reg == TK_DIV))
        else $error("divider started with zero divisor");

endmodule

`default_nettype wire
